[src/frl_pkg.sv]
// Package for the flash ring record log: sizes, codes, types and helper functions.
package frl_pkg;

	localparam int MAX_SECTORS      = 4;
	localparam int SLOTS_PER_SECTOR = 16;
	localparam int SLOT_BYTES       = 16;
	localparam int TOTAL_SLOTS      = MAX_SECTORS * SLOTS_PER_SECTOR;
	localparam int SLOT_W           = $clog2(TOTAL_SLOTS);
	localparam int RING_W           = $clog2(TOTAL_SLOTS + 1);
	localparam int NSEC_W           = $clog2(MAX_SECTORS + 1);

	localparam int FUNC_W   = 3;
	localparam int IDX_W    = 32;
	localparam int ADDR_W   = 32;
	localparam int DATA_W   = 64;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int SIU_W    = 3;
	localparam int HDR_W    = IDX_W + LEN_W;
	localparam int MAX_LEN  = 8;
	localparam int MOD_W    = IDX_W + 1;
	localparam int MOD_CNT_W = $clog2(MOD_W);

	localparam int SIU_RESET = 4;
	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(127);
	localparam logic [IDX_W-1:0]   IDX_LAST  = '1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECTORS_IN_USE = 1'b1;

	localparam logic [FUNC_W-1:0] FUNC_APPEND      = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ_INDEX  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ_LATEST = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_COUNT       = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SCAN_END,
		ST_MOD,
		ST_RD_ISSUE,
		ST_RD_OUT
	} frl_state_t;

	typedef struct packed {
		logic                done;
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   payload;
		logic [LEN_W-1:0]    len;
		logic [IDX_W-1:0]    index;
		logic [COUNT_W-1:0]  count;
		logic [ADDR_W-1:0]   addr;
	} frl_result_t;

	function automatic logic is_sector_start(input logic [SLOT_W-1:0] slot);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < MAX_SECTORS; k++) begin
			if (int'(slot) == k * SLOTS_PER_SECTOR)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic logic [DATA_W-1:0] mask_payload(input logic [DATA_W-1:0] p,
			input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_LEN; b++) begin
			if (b < int'(len))
				m[b*8 +: 8] = p[b*8 +: 8];
		end
		return m;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_address(input logic [ADDR_W-1:0] base,
			input logic [SLOT_W-1:0] slot);
		return base + ADDR_W'(32'(slot) * SLOT_BYTES);
	endfunction

endpackage

[src/frl_ram.sv]
// Generic single-port RAM with registered read data.
module frl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

[src/flash_ring_record_log_unit.sv]
// Flash ring record log: ring of record slots in two RAMs with a command sequencer.
//
// Command channel: a word is taken when start is high and busy is low; func selects
// append, read by index, read latest, count or clear. Each command gives one result
// word on the output ports, marked by done for exactly one cycle; the receiver
// cannot hold it off. Outputs read zero while done is low.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is the
// base address, index 1 the number of sectors in the ring. Write only while idle.
// With n sectors in the ring: clear / unknown func / rejected append / empty store
//   are answered at once; append writes one slot; read latest reads the newest;
//   count scans n sectors; read by index scans (and stops there when no oldest
//   record is found or the index is out of range), then a one-bit-per-cycle
//   remainder unit folds the slot offset into the ring and the slot is read. The
//   oldest-record scan reads the first slot of each sector from the header RAM.
// One command at a time; busy stays high until the cycle its result is shown.
// Reset clears the used marks of all slots at once (flip-flops beside the header
// RAM), empties the log and loads base address 0 and 4 sectors; no clearing pass.
module flash_ring_record_log_unit import frl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [IDX_W-1:0]     record_index,
	input  logic [DATA_W-1:0]    payload,
	input  logic [LEN_W-1:0]     length,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [DATA_W-1:0]    read_payload,
	output logic [LEN_W-1:0]     read_length,
	output logic [IDX_W-1:0]     found_index,
	output logic [COUNT_W-1:0]   record_count,
	output logic [ADDR_W-1:0]    record_address,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	frl_state_t state_q, state_d;
	frl_result_t res_q, res_d;

	logic [ADDR_W-1:0]      base_q;
	logic [SIU_W-1:0]       siu_q;
	logic [TOTAL_SLOTS-1:0] valid_q, valid_d;
	logic [SLOT_W-1:0]      newest_slot_q;
	logic [IDX_W-1:0]       newest_num_q;

	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]  want_q;
	logic [DATA_W-1:0] pay_q;
	logic [LEN_W-1:0]  len_q;

	logic [NSEC_W-1:0] sec_q;
	logic              found_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [SLOT_W-1:0] oslot_q;
	logic [SLOT_W-1:0] scan_slot_s1;

	logic [MOD_W-1:0]     mod_x_q;
	logic [RING_W-1:0]    mod_rem_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [SLOT_W-1:0]    rd_slot_q;

	logic accept;
	logic [NSEC_W-1:0] ring_n;
	logic [RING_W-1:0] ring_slots;

	logic              wrap_all, fresh;
	logic [RING_W-1:0] next_raw;
	logic [SLOT_W-1:0] next_slot;
	logic [IDX_W-1:0]  app_idx;

	logic [SLOT_W-1:0] scan_addr;
	logic [IDX_W-1:0]  hdr_idx;
	logic              scan_better;
	logic [RING_W:0]   mod_t;
	logic [RING_W-1:0] mod_rem_next;
	logic [IDX_W-1:0]  diff;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_addr;
	logic [HDR_W-1:0]  hdr_wdata, hdr_rdata;
	logic [DATA_W-1:0] data_rdata;
	logic              rd_used;

	frl_ram #(.WIDTH(HDR_W), .DEPTH(TOTAL_SLOTS)) u_hdr_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (hdr_wdata),
		.rdata (hdr_rdata)
	);

	frl_ram #(.WIDTH(DATA_W), .DEPTH(TOTAL_SLOTS)) u_data_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (pay_q),
		.rdata (data_rdata)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done           = res_q.done;
	assign status         = res_q.status;
	assign read_payload   = res_q.payload;
	assign read_length    = res_q.len;
	assign found_index    = res_q.index;
	assign record_count   = res_q.count;
	assign record_address = res_q.addr;

	// ring geometry
	always_comb begin
		if (siu_q == '0)
			ring_n = NSEC_W'(1);
		else if (int'(siu_q) > MAX_SECTORS)
			ring_n = NSEC_W'(MAX_SECTORS);
		else
			ring_n = NSEC_W'(siu_q);
		ring_slots = RING_W'(32'(ring_n) * SLOTS_PER_SECTOR);
	end

	// append slot and index
	assign wrap_all  = (newest_num_q == IDX_LAST);
	assign fresh     = wrap_all || (newest_num_q == '0);
	assign next_raw  = fresh ? '0 : RING_W'(newest_slot_q) + RING_W'(1);
	assign next_slot = (next_raw >= ring_slots) ? '0 : SLOT_W'(next_raw);
	assign app_idx   = fresh ? IDX_W'(1) : newest_num_q + IDX_W'(1);
	assign hdr_wdata = {app_idx, len_q};

	// scan and remainder datapath
	assign scan_addr    = SLOT_W'(32'(sec_q) * SLOTS_PER_SECTOR);
	assign hdr_idx      = hdr_rdata[HDR_W-1 -: IDX_W];
	assign scan_better  = valid_q[scan_slot_s1] && (!found_q || hdr_idx < oidx_q);
	assign mod_t        = {mod_rem_q, mod_x_q[MOD_W-1]};
	assign mod_rem_next = (mod_t >= {1'b0, ring_slots}) ?
		RING_W'(mod_t - {1'b0, ring_slots}) : RING_W'(mod_t);
	assign diff         = newest_num_q - oidx_q;
	assign rd_used      = valid_q[rd_slot_q];

	// used marks after this cycle
	always_comb begin
		valid_d = valid_q;
		if (state_q == ST_IDLE && accept && func == FUNC_CLEAR)
			valid_d = '0;
		if (state_q == ST_APPEND) begin
			if (wrap_all)
				valid_d = '0;
			if (is_sector_start(next_slot)) begin
				for (int s = 0; s < TOTAL_SLOTS; s++) begin
					if (s >= int'(next_slot) && s < int'(next_slot) + SLOTS_PER_SECTOR)
						valid_d[s] = 1'b0;
				end
			end
			valid_d[next_slot] = 1'b1;
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		res_d    = '0;
		mem_we   = 1'b0;
		mem_addr = rd_slot_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func) inside
						FUNC_APPEND: begin
							if (int'(length) > MAX_LEN) begin
								res_d.done   = 1'b1;
								res_d.status = STAT_TOO_LONG;
							end else begin
								state_d = ST_APPEND;
							end
						end
						FUNC_READ_INDEX, FUNC_COUNT: begin
							if (newest_num_q == '0) begin
								res_d.done   = 1'b1;
								res_d.status = STAT_EMPTY;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						FUNC_READ_LATEST: begin
							if (newest_num_q == '0) begin
								res_d.done   = 1'b1;
								res_d.status = STAT_EMPTY;
							end else begin
								state_d = ST_RD_ISSUE;
							end
						end
						default: begin
							res_d.done   = 1'b1;
							res_d.status = STAT_OK;
						end
					endcase
				end
			end
			ST_APPEND: begin
				mem_we       = 1'b1;
				mem_addr     = next_slot;
				res_d.done   = 1'b1;
				res_d.status = STAT_OK;
				res_d.index  = app_idx;
				res_d.addr   = slot_address(base_q, next_slot);
				state_d      = ST_IDLE;
			end
			ST_SCAN_RD: begin
				mem_addr = scan_addr;
				state_d  = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				state_d = (sec_q + NSEC_W'(1) == ring_n) ? ST_SCAN_END : ST_SCAN_RD;
			end
			ST_SCAN_END: begin
				state_d = ST_IDLE;
				if (!found_q) begin
					res_d.done   = 1'b1;
					res_d.status = STAT_EMPTY;
				end else if (func_q == FUNC_COUNT) begin
					res_d.done = 1'b1;
					if (oidx_q > newest_num_q) begin
						res_d.status = STAT_EMPTY;
					end else begin
						res_d.status = STAT_OK;
						res_d.count  = (diff >= IDX_W'(COUNT_MAX - 1'b1)) ?
							COUNT_MAX : COUNT_W'(diff + IDX_W'(1));
					end
				end else if (want_q < oidx_q || want_q > newest_num_q) begin
					res_d.done   = 1'b1;
					res_d.status = STAT_RANGE;
				end else begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == '0)
					state_d = ST_RD_ISSUE;
			end
			ST_RD_ISSUE: begin
				state_d = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				state_d    = ST_IDLE;
				res_d.done = 1'b1;
				if (func_q == FUNC_READ_INDEX && (!rd_used || hdr_idx != want_q)) begin
					res_d.status = STAT_RANGE;
				end else begin
					res_d.status  = STAT_OK;
					res_d.payload = data_rdata;
					res_d.len     = rd_used ? hdr_rdata[LEN_W-1:0] : '0;
					res_d.index   = rd_used ? hdr_idx : '0;
					res_d.addr    = slot_address(base_q, rd_slot_q);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_q         <= '0;
			base_q        <= '0;
			siu_q         <= SIU_W'(SIU_RESET);
			valid_q       <= '0;
			newest_slot_q <= '0;
			newest_num_q  <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			valid_q <= valid_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE_ADDRESS:   base_q <= cfg_data;
					REG_SECTORS_IN_USE: siu_q  <= cfg_data[SIU_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && accept && func == FUNC_CLEAR) begin
				newest_slot_q <= '0;
				newest_num_q  <= '0;
			end
			if (state_q == ST_APPEND) begin
				newest_slot_q <= next_slot;
				newest_num_q  <= app_idx;
			end
		end
	end

	// command and scan working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q    <= func;
					want_q    <= record_index;
					pay_q     <= mask_payload(payload, length);
					len_q     <= length;
					sec_q     <= '0;
					found_q   <= 1'b0;
					rd_slot_q <= newest_slot_q;
				end
			end
			ST_SCAN_RD: begin
				scan_slot_s1 <= scan_addr;
			end
			ST_SCAN_CMP: begin
				sec_q <= sec_q + NSEC_W'(1);
				if (scan_better) begin
					found_q <= 1'b1;
					oidx_q  <= hdr_idx;
					oslot_q <= scan_slot_s1;
				end
			end
			ST_SCAN_END: begin
				mod_x_q   <= MOD_W'(oslot_q) + MOD_W'(want_q - oidx_q);
				mod_rem_q <= '0;
				mod_cnt_q <= MOD_CNT_W'(MOD_W - 1);
			end
			ST_MOD: begin
				mod_rem_q <= mod_rem_next;
				mod_x_q   <= {mod_x_q[MOD_W-2:0], 1'b0};
				mod_cnt_q <= mod_cnt_q - MOD_CNT_W'(1);
				if (mod_cnt_q == '0)
					rd_slot_q <= SLOT_W'(mod_rem_next);
			end
			default: ;
		endcase
	end

endmodule
